// ===== rtl/gfg_pkg.sv =====
package gfg_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_SCALE = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_SPD    = 2'd1,
		REG_RAMP   = 2'd2,
		REG_LENGTH = 2'd3
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIVIDE,
		ST_FETCH,
		ST_OUT
	} state_t;

	localparam int FREQ_W = 32;

endpackage

// ===== rtl/glide_frequency_generator_top.sv =====
// Glide frequency generator. Every input item gives exactly one result item, and the block
// takes no new item until the result of the current one has been taken. A load, an unused
// action, a start in off, reserved or empty scale mode and a tick outside a scale glide go
// straight to the output state; a tick during a scale glide first reads the entry of its
// next degree in a fetch state. A start in scale mode walks the valid scale entries one a
// cycle through one pair of subtract and compare units, then fetches its entry. A start in
// free mode runs a restoring divider one quotient bit a cycle. The next item is accepted
// only once the result has been taken and m_tvalid has dropped. Scale entries sit in one
// memory with separate write and read addresses; unwritten entries read as undefined.
module glide_frequency_generator_top #(
	parameter int SCALE_DEPTH    = 32,
	parameter int FREQ_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [19:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action, start_freq, end_freq, entry_index, entry_value, zero pad
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// frequency, gliding, zero pad
	output logic [39:0]  m_tdata
);
	localparam int AW = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
	localparam int LW = $clog2(SCALE_DEPTH + 1);
	localparam logic [63:0] HZ_RAW = 64'd440 << FREQ_FRAC_BITS;
	localparam logic [31:0] HZ440 = (HZ_RAW > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : HZ_RAW[31:0];

	logic [1:0]  mode_q;
	logic [19:0] spd_q;
	logic [15:0] ramp_steps_q;
	logic [5:0]  slen_q;

	logic [31:0] held_q, goal_q, inc_q;
	logic        inc_neg_q;
	logic [15:0] left_q;
	logic [AW-1:0] dnow_q, dgoal_q;
	logic [19:0] tick_q;
	logic        busy_q;

	logic [31:0] mem [SCALE_DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic        rd_en;

	gfg_pkg::state_t st_q;
	logic [1:0]  act_q;
	logic [31:0] s_q, e_q;
	logic [AW:0] idx_q;
	logic        phase_q;
	logic [31:0] bds_q, bde_q;
	logic [AW-1:0] bis_q, bie_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;

	logic [1:0]  in_act;
	logic [31:0] in_s, in_e, in_val;
	logic [4:0]  in_idx;
	assign in_act = s_tdata[1:0];
	assign in_s   = s_tdata[33:2];
	assign in_e   = s_tdata[65:34];
	assign in_idx = s_tdata[70:66];
	assign in_val = s_tdata[102:71];

	logic [LW-1:0] vlen;
	assign vlen = (32'(slen_q) > SCALE_DEPTH) ? LW'(SCALE_DEPTH) : LW'(slen_q);

	logic [15:0] nsteps;
	assign nsteps = (ramp_steps_q == 16'd0) ? 16'd1 : ramp_steps_q;

	assign s_tready = (st_q == gfg_pkg::ST_IDLE) && !m_tvalid;
	logic acc;
	assign acc = s_tvalid && s_tready;

	// a scale tick that moves one degree
	logic scale_step;
	assign scale_step = (vlen != '0) && (dnow_q != dgoal_q) && (tick_q + 1'b1 >= spd_q);

	// shared difference unit
	logic [31:0] dabs_s, dabs_e;
	assign dabs_s = (rd_q > s_q) ? rd_q - s_q : s_q - rd_q;
	assign dabs_e = (rd_q > e_q) ? rd_q - e_q : e_q - rd_q;

	logic [32:0] trial;
	assign trial = {rem_q[31:0], quo_q[31]} - {17'd0, nsteps};

	always_ff @(posedge clk) begin
		if (acc && in_act == gfg_pkg::ACT_LOAD && 32'(in_idx) < SCALE_DEPTH)
			mem[AW'(in_idx)] <= in_val;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	gfg_pkg::state_t st_d;
	always_comb begin
		st_d = st_q;
		rd_en = 1'b0;
		rd_addr = '0;
		case (st_q)
			gfg_pkg::ST_IDLE: begin
				if (acc) begin
					if (in_act == gfg_pkg::ACT_START && mode_q == gfg_pkg::MODE_SCALE
							&& vlen != '0) begin
						st_d = gfg_pkg::ST_SEARCH;
						rd_en = 1'b1;
					end else if (in_act == gfg_pkg::ACT_START && mode_q == gfg_pkg::MODE_FREE)
						st_d = gfg_pkg::ST_DIVIDE;
					else if (in_act == gfg_pkg::ACT_TICK && busy_q
							&& mode_q == gfg_pkg::MODE_SCALE) begin
						st_d = gfg_pkg::ST_FETCH;
						rd_en = 1'b1;
						rd_addr = (dnow_q < dgoal_q) ? dnow_q + 1'b1 : dnow_q - 1'b1;
					end else
						st_d = gfg_pkg::ST_OUT;
				end
			end
			gfg_pkg::ST_SEARCH: begin
				rd_en = 1'b1;
				rd_addr = idx_q[AW-1:0] + 1'b1;
				if (phase_q) begin
					rd_addr = bis_q;
					st_d = gfg_pkg::ST_FETCH;
				end
			end
			gfg_pkg::ST_DIVIDE: if (cnt_q == 6'd31) st_d = gfg_pkg::ST_OUT;
			gfg_pkg::ST_FETCH: st_d = gfg_pkg::ST_OUT;
			gfg_pkg::ST_OUT: st_d = gfg_pkg::ST_IDLE;
			default: st_d = gfg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gfg_pkg::ST_IDLE;
			mode_q <= gfg_pkg::MODE_OFF;
			spd_q <= 20'd4410;
			ramp_steps_q <= 16'd2205;
			slen_q <= 6'd0;
			held_q <= HZ440;
			goal_q <= HZ440;
			inc_q <= '0;
			inc_neg_q <= 1'b0;
			left_q <= '0;
			dnow_q <= '0;
			dgoal_q <= '0;
			tick_q <= '0;
			busy_q <= 1'b0;
			m_tvalid <= 1'b0;
			phase_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			act_q <= '0;
			s_q <= '0;
			e_q <= '0;
			bds_q <= '0;
			bde_q <= '0;
			bis_q <= '0;
			bie_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else begin
			st_q <= st_d;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					gfg_pkg::REG_MODE: begin
						mode_q <= cfg_data[1:0];
						if (cfg_data[1:0] == gfg_pkg::MODE_OFF
								|| cfg_data[1:0] == gfg_pkg::MODE_RSVD) begin
							busy_q <= 1'b0;
							tick_q <= '0;
							left_q <= '0;
							goal_q <= held_q;
						end
					end
					gfg_pkg::REG_SPD: spd_q <= cfg_data;
					gfg_pkg::REG_RAMP: ramp_steps_q <= cfg_data[15:0];
					gfg_pkg::REG_LENGTH: slen_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			case (st_q)
				gfg_pkg::ST_IDLE: if (acc) begin
					act_q <= (in_act == gfg_pkg::ACT_TICK && !scale_step)
						? gfg_pkg::ACT_NONE : in_act;
					s_q <= in_s;
					e_q <= in_e;
					idx_q <= '0;
					phase_q <= 1'b0;
					cnt_q <= '0;
					quo_q <= (in_e >= in_s) ? in_e - in_s : in_s - in_e;
					rem_q <= '0;
					if (in_act == gfg_pkg::ACT_START) begin
						if (mode_q == gfg_pkg::MODE_FREE) begin
							held_q <= in_s;
							goal_q <= in_e;
							inc_neg_q <= in_e < in_s;
							left_q <= (in_s == in_e) ? 16'd1 : nsteps;
							busy_q <= 1'b1;
						end else if (!(mode_q == gfg_pkg::MODE_SCALE && vlen != '0)) begin
							held_q <= in_e;
							goal_q <= in_e;
							left_q <= '0;
							busy_q <= 1'b0;
						end
					end else if (in_act == gfg_pkg::ACT_TICK && busy_q) begin
						if (mode_q == gfg_pkg::MODE_FREE) begin
							if (left_q <= 16'd1) begin
								held_q <= goal_q;
								left_q <= '0;
								busy_q <= 1'b0;
							end else begin
								held_q <= inc_neg_q ? held_q - inc_q : held_q + inc_q;
								left_q <= left_q - 1'b1;
							end
						end else if (mode_q == gfg_pkg::MODE_SCALE) begin
							if (vlen == '0 || dnow_q == dgoal_q) begin
								busy_q <= 1'b0;
							end else if (scale_step) begin
								tick_q <= '0;
								dnow_q <= (dnow_q < dgoal_q) ? dnow_q + 1'b1 : dnow_q - 1'b1;
								if (((dnow_q < dgoal_q) ? dnow_q + 1'b1 : dnow_q - 1'b1)
										== dgoal_q)
									busy_q <= 1'b0;
							end else begin
								tick_q <= tick_q + 1'b1;
							end
						end else
							busy_q <= 1'b0;
					end
				end
				gfg_pkg::ST_SEARCH: begin
					if (!phase_q) begin
						if (idx_q == '0 || dabs_s < bds_q) begin
							bds_q <= dabs_s;
							bis_q <= idx_q[AW-1:0];
						end
						if (idx_q == '0 || dabs_e < bde_q) begin
							bde_q <= dabs_e;
							bie_q <= idx_q[AW-1:0];
						end
						if (32'(idx_q) + 1 >= 32'(vlen))
							phase_q <= 1'b1;
						else
							idx_q <= idx_q + 1'b1;
					end else begin
						dnow_q <= bis_q;
						dgoal_q <= bie_q;
						tick_q <= '0;
						busy_q <= (bis_q != bie_q);
					end
				end
				gfg_pkg::ST_DIVIDE: begin
					cnt_q <= cnt_q + 1'b1;
					quo_q <= {quo_q[30:0], ~trial[32]};
					rem_q <= trial[32] ? {rem_q[31:0], quo_q[31]} : trial;
					if (cnt_q == 6'd31)
						inc_q <= {quo_q[30:0], ~trial[32]};
				end
				gfg_pkg::ST_FETCH: begin
					if (act_q == gfg_pkg::ACT_START)
						held_q <= rd_q;
					else if (act_q == gfg_pkg::ACT_TICK && 32'(dnow_q) < 32'(vlen))
						held_q <= rd_q;
				end
				gfg_pkg::ST_OUT: m_tvalid <= 1'b1;
				default: ;
			endcase
		end
	end

	assign m_tdata = {7'd0, busy_q, held_q};

	property p_out_idle;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> st_q == gfg_pkg::ST_IDLE;
	endproperty
	a_out_idle: assert property (p_out_idle) else $error("result shown while working");

	property p_div_len;
		@(posedge clk) disable iff (!arst_n)
			(st_q == gfg_pkg::ST_DIVIDE && cnt_q == 6'd31) |=> st_q == gfg_pkg::ST_OUT;
	endproperty
	a_div_len: assert property (p_div_len) else $error("divider overran");

	property p_deg;
		@(posedge clk) disable iff (!arst_n)
			(busy_q && mode_q == gfg_pkg::MODE_SCALE && st_q == gfg_pkg::ST_IDLE)
			|-> 32'(dgoal_q) < SCALE_DEPTH;
	endproperty
	a_deg: assert property (p_deg) else $error("degree goal out of range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] start_freq;
		logic [31:0] end_freq;
		logic [4:0]  entry_index;
		logic [31:0] entry_value;
	} glide_item_t;

	typedef struct packed {
		logic [31:0] frequency;
		logic        gliding;
	} freq_out_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [19:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;

	glide_frequency_generator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// glide model state
	logic [1:0]  mdl_mode;
	logic [19:0] mdl_spd;
	logic [15:0] mdl_ramp;
	logic [5:0]  mdl_len;
	logic [31:0] held_freq;
	logic [32:0] ramp_inc;
	logic [15:0] ramp_left;
	logic [31:0] ramp_goal;
	logic [4:0]  deg_now;
	logic [4:0]  deg_goal;
	logic [19:0] tick_cnt;
	logic        busy;
	logic [31:0] scale_tab [32];
	bit          tab_written [32];

	glide_item_t pending_items[$];
	freq_out_t   expected_freqs[$];
	int          errors;
	int          items_sent;
	int          results_seen;
	bit          quiet_tail;
	bit          hold_long;
	int          s_gap;
	int          m_gap;

	function automatic int active_len();
		return (mdl_len > 32) ? 32 : int'(mdl_len);
	endfunction

	function automatic logic [4:0] snap_degree(logic [31:0] f, int n);
		logic [4:0]  best;
		logic [31:0] bd;
		logic [31:0] d;
		best = 0;
		bd = (scale_tab[0] > f) ? scale_tab[0] - f : f - scale_tab[0];
		for (int i = 1; i < n; i++) begin
			d = (scale_tab[i] > f) ? scale_tab[i] - f : f - scale_tab[i];
			if (d < bd) begin
				bd = d;
				best = i[4:0];
			end
		end
		return best;
	endfunction

	task automatic model_reset();
		mdl_mode = gfg_pkg::MODE_OFF;
		mdl_spd = 20'd4410;
		mdl_ramp = 16'd2205;
		mdl_len = 6'd0;
		held_freq = 32'd440 << 16;
		ramp_goal = 32'd440 << 16;
		ramp_inc = '0;
		ramp_left = '0;
		deg_now = '0;
		deg_goal = '0;
		tick_cnt = '0;
		busy = 0;
		for (int i = 0; i < 32; i++) begin
			scale_tab[i] = '0;
			tab_written[i] = 0;
		end
	endtask

	task automatic model_write(gfg_pkg::reg_t idx, logic [19:0] v);
		case (idx)
			gfg_pkg::REG_MODE: begin
				mdl_mode = v[1:0];
				if (mdl_mode == gfg_pkg::MODE_OFF || mdl_mode == gfg_pkg::MODE_RSVD) begin
					busy = 0;
					tick_cnt = '0;
					ramp_left = '0;
					ramp_goal = held_freq;
				end
			end
			gfg_pkg::REG_SPD: mdl_spd = v;
			gfg_pkg::REG_RAMP: mdl_ramp = v[15:0];
			gfg_pkg::REG_LENGTH: mdl_len = v[5:0];
			default: ;
		endcase
	endtask

	task automatic glide_step(glide_item_t it);
		int          n;
		logic [16:0] steps;
		logic [31:0] mag;
		freq_out_t   r;
		n = active_len();
		case (gfg_pkg::action_t'(it.action))
			gfg_pkg::ACT_TICK: begin
				if (busy) begin
					if (mdl_mode == gfg_pkg::MODE_FREE) begin
						if (ramp_left <= 1) begin
							held_freq = ramp_goal;
							ramp_left = '0;
							busy = 0;
						end else begin
							held_freq = held_freq + ramp_inc[31:0];
							ramp_left--;
						end
					end else if (mdl_mode == gfg_pkg::MODE_SCALE) begin
						if (n == 0 || deg_now == deg_goal) begin
							busy = 0;
						end else begin
							tick_cnt++;
							if (tick_cnt >= mdl_spd) begin
								tick_cnt = '0;
								if (deg_now < deg_goal) deg_now++;
								else deg_now--;
								if (deg_now < n) held_freq = scale_tab[deg_now];
								if (deg_now == deg_goal) busy = 0;
							end
						end
					end else begin
						busy = 0;
					end
				end
			end
			gfg_pkg::ACT_START: begin
				if (mdl_mode == gfg_pkg::MODE_FREE) begin
					steps = (mdl_ramp == 0) ? 17'd1 : {1'b0, mdl_ramp};
					held_freq = it.start_freq;
					ramp_goal = it.end_freq;
					mag = (it.end_freq >= it.start_freq) ? it.end_freq - it.start_freq
						: it.start_freq - it.end_freq;
					mag = mag / steps;
					ramp_inc = (it.end_freq >= it.start_freq) ? {1'b0, mag} : -{1'b0, mag};
					ramp_left = (it.start_freq == it.end_freq) ? 16'd1 : steps[15:0];
					busy = 1;
				end else if (mdl_mode == gfg_pkg::MODE_SCALE && n > 0) begin
					deg_now = snap_degree(it.start_freq, n);
					deg_goal = snap_degree(it.end_freq, n);
					held_freq = scale_tab[deg_now];
					tick_cnt = '0;
					busy = (deg_now != deg_goal);
				end else begin
					held_freq = it.end_freq;
					ramp_goal = it.end_freq;
					ramp_left = '0;
					busy = 0;
				end
			end
			gfg_pkg::ACT_LOAD: scale_tab[it.entry_index] = it.entry_value;
			default: ;
		endcase
		r.frequency = held_freq;
		r.gliding = busy;
		expected_freqs.push_back(r);
	endtask

	function automatic glide_item_t make_item(gfg_pkg::action_t a, logic [31:0] s,
		logic [31:0] e, logic [4:0] idx, logic [31:0] v);
		glide_item_t it;
		it.action = a;
		it.start_freq = s;
		it.end_freq = e;
		it.entry_index = idx;
		it.entry_value = v;
		return it;
	endfunction

	function automatic logic [31:0] rand_freq();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h00FF_FFFF) << $urandom_range(0, 8);
			2: return {16'($urandom_range(20, 20000)), 16'($urandom())};
			default: return ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	// the predictor runs as the item is queued; config writes happen only when idle
	task automatic queue_item(glide_item_t it);
		if (it.action == gfg_pkg::ACT_START || it.action == gfg_pkg::ACT_TICK) begin
			if (mdl_mode == gfg_pkg::MODE_SCALE && active_len() > 0
					&& it.action == gfg_pkg::ACT_START)
				for (int i = 0; i < active_len(); i++)
					if (!tab_written[i]) it.action = gfg_pkg::ACT_NONE;
		end
		if (it.action == gfg_pkg::ACT_LOAD) tab_written[it.entry_index] = 1;
		glide_step(it);
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_freqs.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(gfg_pkg::reg_t idx, logic [19:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		model_write(idx, v);
	endtask

	task automatic fill_scale(int n);
		logic [31:0] f;
		f = $urandom_range(1, 32'h0100_0000);
		for (int i = 0; i < n; i++) begin
			queue_item(make_item(gfg_pkg::ACT_LOAD, 0, 0, i[4:0], f));
			f = f + $urandom_range(0, 32'h0080_0000);
		end
	endtask

	always #5 clk = ~clk;

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				void'(pending_items.pop_front());
				items_sent <= items_sent + 1;
			end
			if (s_gap > 0) begin
				s_gap <= s_gap - 1;
				if (!(s_tvalid && !s_tready)) s_tvalid <= 0;
			end else if (s_tvalid && !s_tready) begin
				s_tvalid <= 1;
			end else begin
				if (!quiet_tail && $urandom_range(0, 9) == 0) begin
					s_gap <= $urandom_range(1, 8);
					s_tvalid <= 0;
				end else if (pending_items.size() > 0) begin
					s_tvalid <= 1;
					s_tdata <= {1'b0, pending_items[0].entry_value, pending_items[0].entry_index,
						pending_items[0].end_freq, pending_items[0].start_freq,
						pending_items[0].action};
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		freq_out_t got;
		freq_out_t want;
		int        bad;
		if (!arst_n) begin
			m_tready <= 0;
			m_gap <= 0;
		end else begin
			bad = 0;
			if (m_tvalid && m_tready) begin
				got.frequency = m_tdata[31:0];
				got.gliding = m_tdata[32];
				results_seen <= results_seen + 1;
				if (expected_freqs.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h/%b",
						$time, got.frequency, got.gliding);
					bad++;
				end else begin
					want = expected_freqs.pop_front();
					if (got.frequency !== want.frequency) begin
						$display("%0t: frequency mismatch, expected %h, actual %h",
							$time, want.frequency, got.frequency);
						bad++;
					end
					if (got.gliding !== want.gliding) begin
						$display("%0t: gliding mismatch, expected %b, actual %b",
							$time, want.gliding, got.gliding);
						bad++;
					end
				end
				errors <= errors + bad;
			end
			if (hold_long) begin
				m_tready <= 0;
			end else if (m_gap > 0) begin
				m_gap <= m_gap - 1;
				m_tready <= 0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				m_gap <= $urandom_range(1, 8);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = gfg_pkg::REG_MODE;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		quiet_tail = 0;
		hold_long = 0;
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: reset state, off mode, extremes, unused action
		queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F,
			32'hFFFF_FFFF));
		queue_item(make_item(gfg_pkg::ACT_START, 32'h0, 32'hFFFF_FFFF, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_START, 32'hFFFF_FFFF, 32'h0, 0, 0));
		wait_idle();
		// free ramp, short length, up, down, equal
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_FREE);
		write_reg(gfg_pkg::REG_RAMP, 20'd3);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h0, 32'hFFFF_FFFF, 0, 0));
		repeat (4) queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_START, 32'hFFFF_FFFF, 32'h1, 0, 0));
		repeat (2) queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_START, 32'h1234_5678, 32'h1234_5678, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_START, 32'h0, 32'h0010_0000, 0, 0));
		wait_idle();
		// mode write to off mid glide, then ramp length zero
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_OFF);
		write_reg(gfg_pkg::REG_RAMP, 20'd0);
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_FREE);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h10, 32'h20, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		wait_idle();
		// empty scale acts as off; then scale with tie and steps of one
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_SCALE);
		write_reg(gfg_pkg::REG_LENGTH, 20'd0);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h5, 32'h9, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_LOAD, 0, 0, 0, 32'h100));
		queue_item(make_item(gfg_pkg::ACT_LOAD, 0, 0, 1, 32'h300));
		queue_item(make_item(gfg_pkg::ACT_LOAD, 0, 0, 2, 32'h500));
		queue_item(make_item(gfg_pkg::ACT_LOAD, 0, 0, 5'h1F, 32'hFFFF_FFFF));
		wait_idle();
		write_reg(gfg_pkg::REG_LENGTH, 20'd3);
		write_reg(gfg_pkg::REG_SPD, 20'd0);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h200, 32'h500, 0, 0));
		repeat (3) queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		wait_idle();
		// mode change mid scale glide, unused mode
		write_reg(gfg_pkg::REG_SPD, 20'd1);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h500, 32'h100, 0, 0));
		wait_idle();
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_FREE);
		queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		wait_idle();
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_RSVD);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h7, 32'h77, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		wait_idle();

		// full scale, backpressure phase
		write_reg(gfg_pkg::REG_MODE, gfg_pkg::MODE_SCALE);
		write_reg(gfg_pkg::REG_SPD, 20'hFFFFF);
		write_reg(gfg_pkg::REG_LENGTH, 20'd32);
		fill_scale(32);
		queue_item(make_item(gfg_pkg::ACT_START, 32'h0, 32'hFFFF_FFFF, 0, 0));
		repeat (10) queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		hold_long = 1;
		repeat (300) @(posedge clk);
		hold_long = 0;
		wait_idle();
		write_reg(gfg_pkg::REG_LENGTH, 20'd63);
		queue_item(make_item(gfg_pkg::ACT_START, 32'hFFFF_FFFF, 32'h0, 0, 0));
		queue_item(make_item(gfg_pkg::ACT_TICK, 0, 0, 0, 0));
		wait_idle();

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			int m;
			if (ph == 10) quiet_tail = 1;
			m = $urandom_range(0, 3);
			write_reg(gfg_pkg::REG_MODE, 20'(m));
			write_reg(gfg_pkg::REG_RAMP,
				($urandom_range(0, 3) == 0) ? 20'hFFFF : 20'($urandom_range(0, 12)));
			write_reg(gfg_pkg::REG_SPD,
				($urandom_range(0, 5) == 0) ? 20'hFFFFF : 20'($urandom_range(0, 5)));
			if (m == gfg_pkg::MODE_SCALE) begin
				int n;
				n = $urandom_range(1, 32);
				fill_scale(n);
				wait_idle();
				write_reg(gfg_pkg::REG_LENGTH, 20'(n));
			end
			for (int k = 0; k < 42; k++) begin
				int a;
				a = $urandom_range(0, 19);
				if (a < 3)
					queue_item(make_item(gfg_pkg::ACT_START, rand_freq(), rand_freq(),
						5'($urandom()), $urandom()));
				else if (a < 17)
					queue_item(make_item(gfg_pkg::ACT_TICK, $urandom(), $urandom(),
						5'($urandom()), $urandom()));
				else if (a < 19 && m != gfg_pkg::MODE_SCALE)
					queue_item(make_item(gfg_pkg::ACT_LOAD, $urandom(), $urandom(),
						5'($urandom()), $urandom()));
				else
					queue_item(make_item(gfg_pkg::ACT_NONE, $urandom(), $urandom(),
						5'($urandom()), $urandom()));
			end
			wait_idle();
		end

		$display("covered %0d items over off, free, scale and unused modes", items_sent);
		$display("including ramp and degree extremes, empty and oversized scales, %0d results",
			results_seen);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gfg_pkg.sv
rtl/glide_frequency_generator_top.sv
bench/testbench.sv
